### rtl/core/dbbhc_pkg.sv
// Package for the dual bearing blend heading controller.
// Holds op codes, register indexes, constants and the sequencer state type.
package dbbhc_pkg;

  localparam logic [1:0] OP_BODY = 2'd0;
  localparam logic [1:0] OP_CAM  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_EN   = 2'd3;

  localparam logic [2:0] REG_BODY_WEIGHT  = 3'd0;
  localparam logic [2:0] REG_MAX_TURN     = 3'd1;
  localparam logic [2:0] REG_NOM_FWD      = 3'd2;
  localparam logic [2:0] REG_MAX_FWD      = 3'd3;
  localparam logic [2:0] REG_STOP_TO      = 3'd4;
  localparam logic [2:0] REG_EQ_MIN_AREA  = 3'd5;
  localparam logic [2:0] REG_EQ_MAX_BEAR  = 3'd6;
  localparam logic [2:0] REG_EQ_HOLD      = 3'd7;

  localparam int CFG_W = 20;

  // yaw disagreement fade window, Q3.12
  localparam logic signed [17:0] GAP_LO = 18'sd819;
  localparam logic signed [17:0] GAP_HI = 18'sd2867;
  // box area fade window, square pixels
  localparam logic [19:0] AREA_LO = 20'd800;
  localparam logic [19:0] AREA_HI = 20'd2000;
  localparam logic [16:0] ALIGN_LIMIT = 17'd1024;

  // Sequencer steps; the shared multiplier is loaded in AREA, MUL_A, MUL_K1,
  // MUL_K2, MUL_H1 and MUL_H2.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREA,
    ST_FRESH,
    ST_GEOM,
    ST_MUL_A,
    ST_MUL_K1,
    ST_MUL_K2,
    ST_MUL_H1,
    ST_MUL_H2,
    ST_CMD,
    ST_OUT
  } state_t;

endpackage

### rtl/core/dbbhc_mul.sv
// Shared registered signed multiplier for the heading controller.
// Stand-alone; takes nothing from the package.
module dbbhc_mul (
  input  logic               clk,
  input  logic signed [24:0] a,
  input  logic signed [17:0] b,
  output logic signed [42:0] p
);

  logic signed [42:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= 43'(a * b);
  end

  assign p = p_r;

endmodule

### rtl/core/dual_bearing_blend_heading_control.sv
// Dual bearing blend heading controller.
// Channels: in_ valid/ready item, out_ valid/ready result, cfg_ write port.
// Each accepted item yields exactly one result item. Between accept and
// result valid a sequencer walks the blend through one shared registered
// multiplier (box area, area fade division, two weight products, two
// heading products), then the clamps. in_ready is high only while the
// sequencer is idle and the result register is empty, so a new item is
// accepted only after the previous result has been taken.
// The result sits in an output register until taken; while the receiver
// stalls the block holds the result and accepts no new item.
// Reset (rst_n low, synchronous) clears the state flags, out_valid and the
// stored detections and loads register defaults 2048, 2048, 41, 82, 1000, 3000, 1024, 1000.
// Configuration writes take effect at once; the user must make them only while idle, as the block does not check.
// Ops: body detection, camera detection, timeout tick, set enable.
// Detections and enable updates are ignored fields-wise when not relevant.
module dual_bearing_blend_heading_control
  import dbbhc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_now_ms,
  input  logic signed [15:0] in_bearing,
  input  logic [9:0]         in_box_width,
  input  logic [9:0]         in_box_height,
  input  logic               in_enable_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_emit_params,
  output logic signed [15:0] out_forward_step,
  output logic signed [15:0] out_turn_step,
  output logic               out_start_walking,
  output logic               out_stop_walking,
  output logic               out_equipped,
  output logic               out_equipped_changed,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  state_t state_r, state_nxt;

  // configuration
  logic [12:0] body_weight_r;
  logic [14:0] max_turn_r, max_fwd_r, eq_max_bear_r;
  logic signed [15:0] nom_fwd_r;
  logic [15:0] stop_to_r, eq_hold_r;
  logic [19:0] eq_min_area_r;

  // block state
  logic enabled_r, walking_r, paused_r, equipped_r, any_seen_r;
  logic body_seen_r, cam_seen_r, eq_set_r;
  logic [31:0] last_any_r, body_time_r, cam_time_r, eq_time_r;
  logic signed [15:0] body_yaw_r, cam_yaw_r;
  logic [19:0] body_area_r, cam_area_r;

  // item latch
  logic [1:0]  op_r;
  logic [31:0] now_r;
  logic signed [15:0] yaw_r;
  logic [9:0]  bw_r, bh_r;
  logic        en_r;

  // working registers
  logic hc_r, hb_r;
  logic signed [15:0] ycam_r, ybody_r;
  logic [19:0] area_r;
  logic [12:0] geom_r, dist_r;
  logic        k_full_r;
  logic [12:0] k_r;
  logic signed [42:0] hsum_r;
  logic signed [16:0] head_r;

  // result register
  logic o_valid_r, o_emit_r, o_start_r, o_stop_r, o_eq_r, o_eqc_r;
  logic signed [15:0] o_fwd_r, o_turn_r;

  // shared multiplier
  logic signed [24:0] ma;
  logic signed [17:0] mb;
  logic signed [42:0] mp;

  dbbhc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  // blend weight; a full base*geom product of 2^24 leaves the weight at dist
  wire [12:0] k_w = k_full_r ? dist_r : 13'(mp >>> 24);

  assign in_ready = (state_r == ST_IDLE) && !o_valid_r;
  wire in_acc = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_AREA;
      ST_AREA:   state_nxt = ST_FRESH;
      ST_FRESH:  state_nxt = ST_GEOM;
      ST_GEOM:   state_nxt = ST_MUL_A;
      ST_MUL_A:  state_nxt = ST_MUL_K1;
      ST_MUL_K1: state_nxt = ST_MUL_K2;
      ST_MUL_K2: state_nxt = ST_MUL_H1;
      ST_MUL_H1: state_nxt = ST_MUL_H2;
      ST_MUL_H2: state_nxt = ST_CMD;
      ST_CMD:    state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      ST_AREA:   begin ma = 25'(bw_r); mb = 18'(bh_r); end
      // (2000 - a) * 4096 / 1200 is taken as (2000 - a) * 55924 >> 14,
      // at most one short, corrected below
      ST_MUL_A:  begin ma = 25'(AREA_HI - area_r); mb = 18'sd55924; end
      ST_MUL_K1: begin
        ma = 25'(body_weight_r > 13'd4096 ? 13'd4096 : body_weight_r);
        mb = 18'(geom_r);
      end
      ST_MUL_K2: begin ma = mp[24:0]; mb = 18'(dist_r); end
      ST_MUL_H1: begin ma = 25'(14'd4096 - 14'(k_w)); mb = 18'(ycam_r); end
      ST_MUL_H2: begin ma = 25'(k_r); mb = 18'(ybody_r); end
      default: ;
    endcase
  end

  wire [31:0] dt_cam  = now_r - cam_time_r;
  wire [31:0] dt_body = now_r - body_time_r;
  wire hc_w = cam_seen_r && (dt_cam <= 32'(stop_to_r));
  wire hb_w = body_seen_r && (dt_body <= 32'(stop_to_r));
  wire signed [16:0] dyaw = 17'(ybody_r) - 17'(ycam_r);
  wire [16:0] dabs = dyaw[16] ? 17'(-dyaw) : 17'(dyaw);
  wire same_sign = hc_r && hb_r &&
    ((ycam_r > 0 && ybody_r > 0) || (ycam_r < 0 && ybody_r < 0));

  // area division: q0 = x*55924 >> 14 is floor(x*4096/1200) or one less
  wire [19:0] adiff = AREA_HI - area_r;
  wire [13:0] q0 = 14'(mp >>> 14);
  wire [33:0] rem = 34'(adiff) * 34'd4096 - 34'(q0) * 34'd1200;
  wire [13:0] q1 = (rem >= 34'd1200) ? q0 + 14'd1 : q0;

  wire signed [42:0] s_w = hsum_r + mp + 43'sd2048;
  wire signed [16:0] h_w = 17'(s_w >>> 12);
  wire [16:0] habs = head_r[16] ? 17'(-head_r) : 17'(head_r);
  wire signed [16:0] mt = 17'(max_turn_r);
  wire signed [16:0] mf = 17'(max_fwd_r);
  wire signed [16:0] nf = 17'(nom_fwd_r);
  wire signed [16:0] eyaw = hc_r ? 17'(ycam_r) : 17'(ybody_r);
  wire [16:0] eabs = eyaw[16] ? 17'(-eyaw) : 17'(eyaw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      body_weight_r <= 13'd2048; max_turn_r <= 15'd2048; nom_fwd_r <= 16'sd41;
      max_fwd_r <= 15'd82; stop_to_r <= 16'd1000; eq_min_area_r <= 20'd3000;
      eq_max_bear_r <= 15'd1024; eq_hold_r <= 16'd1000;
      enabled_r <= 1'b0; walking_r <= 1'b0; paused_r <= 1'b0; equipped_r <= 1'b0;
      any_seen_r <= 1'b0; body_seen_r <= 1'b0; cam_seen_r <= 1'b0; eq_set_r <= 1'b0;
      last_any_r <= '0; body_time_r <= '0; cam_time_r <= '0; eq_time_r <= '0;
      body_yaw_r <= '0; cam_yaw_r <= '0; body_area_r <= '0; cam_area_r <= '0;
      o_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BODY_WEIGHT: body_weight_r <= cfg_wdata[12:0];
          REG_MAX_TURN:    max_turn_r    <= cfg_wdata[14:0];
          REG_NOM_FWD:     nom_fwd_r     <= cfg_wdata[15:0];
          REG_MAX_FWD:     max_fwd_r     <= cfg_wdata[14:0];
          REG_STOP_TO:     stop_to_r     <= cfg_wdata[15:0];
          REG_EQ_MIN_AREA: eq_min_area_r <= cfg_wdata[19:0];
          REG_EQ_MAX_BEAR: eq_max_bear_r <= cfg_wdata[14:0];
          REG_EQ_HOLD:     eq_hold_r     <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (o_valid_r && out_ready) o_valid_r <= 1'b0;
      if (in_acc) begin
        op_r <= in_op; now_r <= in_now_ms; yaw_r <= in_bearing;
        bw_r <= in_box_width; bh_r <= in_box_height; en_r <= in_enable_value;
      end
      unique case (state_r)
        ST_AREA: begin
          o_emit_r <= 1'b0; o_fwd_r <= '0; o_turn_r <= '0; o_start_r <= 1'b0;
          o_stop_r <= 1'b0; o_eqc_r <= 1'b0;
        end
        ST_FRESH: begin
          // store the detection, then judge freshness next step
          if ((op_r == OP_BODY || op_r == OP_CAM) && enabled_r) begin
            last_any_r <= now_r; any_seen_r <= 1'b1;
            if (op_r == OP_BODY) begin
              body_time_r <= now_r; body_seen_r <= 1'b1; body_yaw_r <= yaw_r;
              body_area_r <= mp[19:0];
            end else begin
              cam_time_r <= now_r; cam_seen_r <= 1'b1; cam_yaw_r <= yaw_r;
              cam_area_r <= mp[19:0];
            end
          end
        end
        ST_GEOM: begin
          hc_r <= hc_w; hb_r <= hb_w;
          ycam_r <= hc_w ? cam_yaw_r : 16'sd0;
          ybody_r <= hb_w ? body_yaw_r : (hc_w ? cam_yaw_r : 16'sd0);
          area_r <= hb_w ? body_area_r : (hc_w ? cam_area_r : 20'd0);
        end
        ST_MUL_A: begin
          if (same_sign && $signed(dabs) > GAP_LO) begin
            if ($signed(dabs) >= GAP_HI) geom_r <= '0;
            else geom_r <= 13'(17'd4096 - 17'd2 * (dabs - 17'(GAP_LO)));
          end else geom_r <= 13'd4096;
        end
        ST_MUL_K1: begin
          if (area_r == 20'd0 || area_r <= AREA_LO) dist_r <= 13'd4096;
          else if (area_r >= AREA_HI) dist_r <= '0;
          else dist_r <= 13'(q1);
        end
        ST_MUL_K2: k_full_r <= mp[24];
        ST_MUL_H1: k_r <= k_w;
        ST_MUL_H2: hsum_r <= mp;
        ST_CMD: head_r <= hb_r && hc_r ? h_w : (hc_r ? 17'(ycam_r) : 17'(ybody_r));
        ST_OUT: begin
          o_valid_r <= 1'b1;
          unique case (op_r)
            OP_BODY, OP_CAM: begin
              if (enabled_r && (hc_r || hb_r)) begin
                o_emit_r <= 1'b1;
                o_turn_r <= 16'(head_r > mt ? mt : (head_r < -mt ? -mt : head_r));
                if (habs < ALIGN_LIMIT)
                  o_fwd_r <= 16'(nf > mf ? mf : (nf < -mf ? -mf : nf));
                if (!walking_r || paused_r) begin
                  o_start_r <= 1'b1; walking_r <= 1'b1;
                end
                paused_r <= 1'b0;
                if (area_r >= eq_min_area_r && eabs <= 17'(eq_max_bear_r)) begin
                  eq_time_r <= now_r; eq_set_r <= 1'b1;
                  if (!equipped_r) begin
                    equipped_r <= 1'b1; o_eqc_r <= 1'b1;
                  end
                  o_eq_r <= 1'b1;
                end else o_eq_r <= equipped_r;
              end else o_eq_r <= equipped_r;
            end
            OP_TICK: begin
              if (enabled_r && walking_r && any_seen_r) begin
                if (now_r - last_any_r > 32'(stop_to_r)) begin
                  paused_r <= 1'b1; o_emit_r <= 1'b1;
                end
                if (equipped_r && eq_set_r && (now_r - eq_time_r > 32'(eq_hold_r)))
                begin
                  equipped_r <= 1'b0; o_eqc_r <= 1'b1; o_eq_r <= 1'b0;
                end else o_eq_r <= equipped_r;
              end else o_eq_r <= equipped_r;
            end
            default: begin
              enabled_r <= en_r;
              if (!en_r) begin
                if (walking_r) begin o_stop_r <= 1'b1; walking_r <= 1'b0; end
                if (equipped_r) begin equipped_r <= 1'b0; o_eqc_r <= 1'b1; end
                o_eq_r <= 1'b0;
                eq_time_r <= '0; eq_set_r <= 1'b0;
              end else o_eq_r <= equipped_r;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign out_valid = o_valid_r;
  assign out_emit_params = o_emit_r;
  assign out_forward_step = o_fwd_r;
  assign out_turn_step = o_turn_r;
  assign out_start_walking = o_start_r;
  assign out_stop_walking = o_stop_r;
  assign out_equipped = o_eq_r;
  assign out_equipped_changed = o_eqc_r;

endmodule
